@@ design/mil_pkg.sv @@
`default_nettype none

package mil_pkg;

  // Fixed widths of the matrix size register and of a row or column index.
  localparam int SIZE_W = 4;
  localparam int IDX_W = 3;

  // Depth of the queue between the load front and the compute back.
  localparam int QUEUE_DEPTH = 4;

  typedef logic signed [31:0] q_t;

  localparam q_t Q_ONE  = 32'sh0001_0000;
  localparam q_t Q_ZERO = 32'sh0000_0000;
  localparam q_t Q_MAX  = 32'sh7fff_ffff;
  localparam q_t Q_MIN  = 32'sh8000_0000;

  // One loaded element with its place in the matrix.
  typedef struct packed {
    q_t               element;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    logic             last;
  } load_item_t;

  // Zero counts as one and anything above the maximum as the maximum.
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] size,
                                                 input logic [SIZE_W-1:0] max_dim);
    logic [SIZE_W-1:0] n;
    n = size;
    if (n == '0) n = SIZE_W'(1);
    if (n > max_dim) n = max_dim;
    return n;
  endfunction

  // Saturating add or subtract of two Q16.16 values.
  function automatic q_t sat_add(input q_t a, input q_t b, input logic sub);
    logic signed [32:0] s;
    if (sub) s = {a[31], a} - {b[31], b};
    else s = {a[31], a} + {b[31], b};
    if (s[32] != s[31]) return s[32] ? Q_MIN : Q_MAX;
    return s[31:0];
  endfunction

  // Round half up of a full product back to Q16.16, then saturate.
  function automatic q_t q_round(input logic signed [63:0] p);
    logic signed [63:0] t;
    logic [47:0] s;
    t = p + 64'sd32768;
    s = t[63:16];
    if (s[47:31] == '0 || s[47:31] == '1) return s[31:0];
    return s[47] ? Q_MIN : Q_MAX;
  endfunction

endpackage

`default_nettype wire

@@ design/mil_if.sv @@
`default_nettype none

// Element stream into the block.
interface mil_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] element;
  modport source(output valid, output element, input ready);
  modport sink(input valid, input element, output ready);
endinterface

// Inverse stream out of the block.
interface mil_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] inverse_element;
  logic               last_element;
  logic               singular;
  modport source(output valid, output inverse_element, output last_element,
                 output singular, input ready);
  modport sink(input valid, input inverse_element, input last_element,
               input singular, output ready);
endinterface

`default_nettype wire

@@ design/mil_front.sv @@
`default_nettype none

module mil_front import mil_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] dim,
  input  logic              cfg_write,
  mil_in_if.sink            operand,
  input  logic              q_full,
  output logic              q_push,
  output load_item_t        q_item
);

  logic [IDX_W-1:0]  row;
  logic [IDX_W-1:0]  col;
  logic [SIZE_W-1:0] n_m1;
  logic              col_end;
  logic              row_end;

  // Tag each element with its place and mark the one that completes the matrix.
  assign n_m1    = dim - SIZE_W'(1);
  assign col_end = (SIZE_W'(col) == n_m1);
  assign row_end = (SIZE_W'(row) == n_m1);

  assign operand.ready  = !q_full;
  assign q_push         = operand.valid && !q_full;
  assign q_item.element = operand.element;
  assign q_item.row     = row;
  assign q_item.col     = col;
  assign q_item.last    = col_end && row_end;

  // Row and column position; a size write drops a partial matrix.
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      row <= '0;
      col <= '0;
    end else if (q_push) begin
      if (col_end) begin
        col <= '0;
        row <= row_end ? '0 : row + IDX_W'(1);
      end else begin
        col <= col + IDX_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ design/mil_queue.sv @@
`default_nettype none

module mil_queue import mil_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  load_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       avail,
  output load_item_t pop_item
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  load_item_t      slots [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;

  assign full     = (count == (PW+1)'(QUEUE_DEPTH));
  assign avail    = (count != '0);
  assign pop_item = slots[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      case ({push, pop})
        2'b10:   count <= count + (PW+1)'(1);
        2'b01:   count <= count - (PW+1)'(1);
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> avail)
    else $error("queue read while empty");
`endif

endmodule

`default_nettype wire

@@ design/mil_div.sv @@
`default_nettype none

module mil_div import mil_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  q_t   num,
  input  q_t   den,
  output logic done,
  output q_t   quo
);

  logic        busy;
  logic        fin;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [47:0] qr;
  logic [31:0] dmag;
  logic        neg;
  logic [31:0] nmag;
  logic [32:0] rem_sh;
  logic        ge;
  logic        pos_over;
  logic        neg_over;

  // Magnitudes of the operands; the numerator is scaled by 2^16.
  assign nmag   = num[31] ? (~num + 32'd1) : num;
  assign rem_sh = {rem, qr[47]};
  assign ge     = (rem_sh >= {1'b0, dmag});

  assign pos_over = (qr[47:31] != '0);
  assign neg_over = (qr[47:32] != '0) || (qr[31] && (qr[30:0] != '0));

  // Restoring division, one quotient bit per cycle, then sign and saturate.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
      done <= 1'b0;
    end else begin
      fin  <= 1'b0;
      done <= fin;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        rem  <= '0;
        qr   <= {nmag, 16'h0000};
        dmag <= den[31] ? (~den + 32'd1) : den;
        neg  <= num[31] ^ den[31];
      end else if (busy) begin
        rem <= ge ? 32'(rem_sh - {1'b0, dmag}) : rem_sh[31:0];
        qr  <= {qr[46:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
      if (fin) begin
        if (neg) quo <= neg_over ? Q_MIN : 32'(32'd0 - qr[31:0]);
        else quo <= pos_over ? Q_MAX : qr[31:0];
      end
    end
  end

`ifndef SYNTHESIS
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst) start |-> den != '0)
    else $error("division by zero started");
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy && !fin)
    else $error("division started while one is running");
`endif

endmodule

`default_nettype wire

@@ design/mil_back.sv @@
`default_nettype none

module mil_back import mil_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [SIZE_W-1:0] dim,
  input  logic              q_valid,
  input  load_item_t        q_item,
  output logic              q_pop,
  mil_out_if.source         result
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [5:0] ST_LOAD     = 6'd0;
  localparam logic [5:0] ST_DISPATCH = 6'd1;
  localparam logic [5:0] ST_N1_RD    = 6'd2;
  localparam logic [5:0] ST_N1_CHK   = 6'd3;
  localparam logic [5:0] ST_N1_DONE  = 6'd4;
  localparam logic [5:0] ST_N2_RD    = 6'd5;
  localparam logic [5:0] ST_N2_CAP   = 6'd6;
  localparam logic [5:0] ST_N2_M1    = 6'd7;
  localparam logic [5:0] ST_N2_M1W   = 6'd8;
  localparam logic [5:0] ST_N2_M1R   = 6'd9;
  localparam logic [5:0] ST_N2_M2W   = 6'd10;
  localparam logic [5:0] ST_N2_M2R   = 6'd11;
  localparam logic [5:0] ST_N2_DIV   = 6'd12;
  localparam logic [5:0] ST_N2_RES   = 6'd13;
  localparam logic [5:0] ST_F_PIV    = 6'd14;
  localparam logic [5:0] ST_F_PIVC   = 6'd15;
  localparam logic [5:0] ST_F_FRD    = 6'd16;
  localparam logic [5:0] ST_F_FDIV   = 6'd17;
  localparam logic [5:0] ST_F_FWR    = 6'd18;
  localparam logic [5:0] ST_F_J1     = 6'd19;
  localparam logic [5:0] ST_F_J2     = 6'd20;
  localparam logic [5:0] ST_F_J3     = 6'd21;
  localparam logic [5:0] ST_F_J4     = 6'd22;
  localparam logic [5:0] ST_F_LAST   = 6'd23;
  localparam logic [5:0] ST_F_LASTC  = 6'd24;
  localparam logic [5:0] ST_U_INIT   = 6'd25;
  localparam logic [5:0] ST_U_A      = 6'd26;
  localparam logic [5:0] ST_U_B      = 6'd27;
  localparam logic [5:0] ST_U_C      = 6'd28;
  localparam logic [5:0] ST_U_D      = 6'd29;
  localparam logic [5:0] ST_U_DRD    = 6'd30;
  localparam logic [5:0] ST_U_DIV    = 6'd31;
  localparam logic [5:0] ST_U_WR     = 6'd32;
  localparam logic [5:0] ST_L_INIT   = 6'd33;
  localparam logic [5:0] ST_L_A      = 6'd34;
  localparam logic [5:0] ST_L_B      = 6'd35;
  localparam logic [5:0] ST_L_C      = 6'd36;
  localparam logic [5:0] ST_L_D      = 6'd37;
  localparam logic [5:0] ST_L_WR     = 6'd38;
  localparam logic [5:0] ST_M_INIT   = 6'd39;
  localparam logic [5:0] ST_M_A      = 6'd40;
  localparam logic [5:0] ST_M_B      = 6'd41;
  localparam logic [5:0] ST_M_C      = 6'd42;
  localparam logic [5:0] ST_M_D      = 6'd43;
  localparam logic [5:0] ST_M_OUT    = 6'd44;
  localparam logic [5:0] ST_ZERO     = 6'd45;
  localparam logic [5:0] ST_EMIT     = 6'd46;
  localparam logic [5:0] ST_DIV_WAIT = 6'd47;

  localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

  logic [5:0]        state;
  logic [5:0]        ret;
  logic [IDX_W-1:0]  k, i, j, r, c;
  q_t                acc, f, piv, t1, res;
  q_t                m2 [4];
  q_t                mul_x, mul_y;
  logic signed [63:0] prod;
  q_t                qm;
  q_t                det;
  logic              sing;
  logic [AW-1:0]     out_count;
  logic [AW-1:0]     total_m1;
  logic [SIZE_W-1:0] n_m1;
  logic [SIZE_W-1:0] n_m2;

  q_t             w_mem [DEPTH];
  q_t             u_mem [DEPTH];
  q_t             l_mem [DEPTH];
  q_t             w_q, u_q, l_q;
  logic           w_we, u_we, l_we;
  logic [AW-1:0]  w_waddr, u_waddr, l_waddr;
  logic [AW-1:0]  w_raddr, u_raddr, l_raddr;
  q_t             w_wdata, u_wdata, l_wdata;

  logic           div_go;
  q_t             div_num, div_den;
  logic           div_done;
  q_t             div_quo;

  logic           o_valid;
  q_t             o_elem;
  logic           o_last;
  logic           o_sing;
  logic           emit_last;

  function automatic logic [AW-1:0] at(input logic [IDX_W-1:0] row,
                                       input logic [IDX_W-1:0] col);
    return AW'(int'(row) * MAX_DIM + int'(col));
  endfunction

  assign n_m1      = dim - SIZE_W'(1);
  assign n_m2      = dim - SIZE_W'(2);
  assign total_m1  = AW'(int'(dim) * int'(dim) - 1);
  assign emit_last = (out_count == total_m1);
  assign qm        = q_round(prod);
  assign det       = sat_add(t1, qm, 1'b1);

  // Shared multiplier with its product register.
  always_ff @(posedge clk) begin
    prod <= mul_x * mul_y;
  end

  mil_div u_div (
    .clk  (clk),
    .rst  (rst),
    .start(div_go),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  // Matrix stores with registered reads.
  always_ff @(posedge clk) begin
    if (w_we) w_mem[w_waddr] <= w_wdata;
    w_q <= w_mem[w_raddr];
  end

  always_ff @(posedge clk) begin
    if (u_we) u_mem[u_waddr] <= u_wdata;
    u_q <= u_mem[u_raddr];
  end

  always_ff @(posedge clk) begin
    if (l_we) l_mem[l_waddr] <= l_wdata;
    l_q <= l_mem[l_raddr];
  end

  // Store addressing for each step of the sequence.
  always_comb begin
    q_pop   = 1'b0;
    w_we    = 1'b0;
    u_we    = 1'b0;
    l_we    = 1'b0;
    w_waddr = '0;
    u_waddr = '0;
    l_waddr = '0;
    w_raddr = '0;
    u_raddr = '0;
    l_raddr = '0;
    w_wdata = acc;
    u_wdata = div_quo;
    l_wdata = acc;
    unique case (state)
      ST_LOAD: begin
        q_pop   = q_valid;
        w_we    = q_valid;
        w_waddr = at(q_item.row, q_item.col);
        w_wdata = q_item.element;
      end
      ST_N1_RD: w_raddr = at('0, '0);
      ST_N2_RD: w_raddr = at(IDX_W'(j[1]), IDX_W'(j[0]));
      ST_F_PIV: w_raddr = at(k, k);
      ST_F_FRD: w_raddr = at(i, k);
      ST_F_FWR: begin
        w_we    = 1'b1;
        w_waddr = at(i, k);
        w_wdata = div_quo;
      end
      ST_F_J1: w_raddr = at(k, j);
      ST_F_J2: w_raddr = at(i, j);
      ST_F_J4: begin
        w_we    = 1'b1;
        w_waddr = at(i, j);
        w_wdata = sat_add(acc, qm, 1'b1);
      end
      ST_F_LAST: w_raddr = at(n_m1[IDX_W-1:0], n_m1[IDX_W-1:0]);
      ST_U_A: begin
        w_raddr = at(r, j);
        u_raddr = at(j, c);
      end
      ST_U_DRD: w_raddr = at(r, r);
      ST_U_WR: begin
        u_we    = 1'b1;
        u_waddr = at(r, c);
      end
      ST_L_A: begin
        w_raddr = at(r, j);
        l_raddr = at(j, c);
      end
      ST_L_WR: begin
        l_we    = 1'b1;
        l_waddr = at(r, c);
      end
      ST_M_A: begin
        u_raddr = at(r, j);
        l_raddr = at(j, c);
      end
      default: ;
    endcase
  end

  // Sequencer: small-size rules, LU factor, triangular inverses, product.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_LOAD;
      o_valid   <= 1'b0;
      out_count <= '0;
      div_go    <= 1'b0;
      sing      <= 1'b0;
    end else begin
      div_go <= 1'b0;
      // The emit step reloads the output register itself when it moves on.
      if (o_valid && result.ready && state != ST_EMIT) o_valid <= 1'b0;
      unique case (state)
        ST_LOAD: begin
          if (q_valid && q_item.last) state <= ST_DISPATCH;
        end
        ST_DISPATCH: begin
          sing <= 1'b0;
          j    <= '0;
          k    <= '0;
          if (dim == SIZE_W'(1)) state <= ST_N1_RD;
          else if (dim == SIZE_W'(2)) state <= ST_N2_RD;
          else state <= ST_F_PIV;
        end
        ST_N1_RD: state <= ST_N1_CHK;
        ST_N1_CHK: begin
          if (w_q == Q_ZERO) begin
            sing  <= 1'b1;
            state <= ST_ZERO;
          end else begin
            div_num <= Q_ONE;
            div_den <= w_q;
            div_go  <= 1'b1;
            ret     <= ST_N1_DONE;
            state   <= ST_DIV_WAIT;
          end
        end
        ST_N1_DONE: begin
          res   <= div_quo;
          ret   <= ST_LOAD;
          state <= ST_EMIT;
        end
        ST_N2_RD: state <= ST_N2_CAP;
        ST_N2_CAP: begin
          m2[j[1:0]] <= w_q;
          if (j == IDX_W'(3)) begin
            state <= ST_N2_M1;
          end else begin
            j     <= j + IDX_ONE;
            state <= ST_N2_RD;
          end
        end
        ST_N2_M1: begin
          mul_x <= m2[0];
          mul_y <= m2[3];
          state <= ST_N2_M1W;
        end
        ST_N2_M1W: state <= ST_N2_M1R;
        ST_N2_M1R: begin
          t1    <= qm;
          mul_x <= m2[1];
          mul_y <= m2[2];
          state <= ST_N2_M2W;
        end
        ST_N2_M2W: state <= ST_N2_M2R;
        ST_N2_M2R: begin
          if (det == Q_ZERO) begin
            sing  <= 1'b1;
            state <= ST_ZERO;
          end else begin
            piv   <= det;
            j     <= '0;
            state <= ST_N2_DIV;
          end
        end
        ST_N2_DIV: begin
          case (j[1:0])
            2'd0:    div_num <= m2[3];
            2'd1:    div_num <= sat_add(Q_ZERO, m2[1], 1'b1);
            2'd2:    div_num <= sat_add(Q_ZERO, m2[2], 1'b1);
            default: div_num <= m2[0];
          endcase
          div_den <= piv;
          div_go  <= 1'b1;
          ret     <= ST_N2_RES;
          state   <= ST_DIV_WAIT;
        end
        ST_N2_RES: begin
          res   <= div_quo;
          ret   <= (j == IDX_W'(3)) ? ST_LOAD : ST_N2_DIV;
          j     <= j + IDX_ONE;
          state <= ST_EMIT;
        end
        ST_F_PIV: state <= ST_F_PIVC;
        ST_F_PIVC: begin
          if (w_q == Q_ZERO) begin
            sing  <= 1'b1;
            state <= ST_ZERO;
          end else begin
            piv   <= w_q;
            i     <= k + IDX_ONE;
            state <= ST_F_FRD;
          end
        end
        ST_F_FRD: state <= ST_F_FDIV;
        ST_F_FDIV: begin
          div_num <= w_q;
          div_den <= piv;
          div_go  <= 1'b1;
          ret     <= ST_F_FWR;
          state   <= ST_DIV_WAIT;
        end
        ST_F_FWR: begin
          f     <= div_quo;
          j     <= k + IDX_ONE;
          state <= ST_F_J1;
        end
        ST_F_J1: state <= ST_F_J2;
        ST_F_J2: begin
          mul_x <= f;
          mul_y <= w_q;
          state <= ST_F_J3;
        end
        ST_F_J3: begin
          acc   <= w_q;
          state <= ST_F_J4;
        end
        ST_F_J4: begin
          if (SIZE_W'(j) == n_m1) begin
            if (SIZE_W'(i) == n_m1) begin
              if (SIZE_W'(k) == n_m2) begin
                state <= ST_F_LAST;
              end else begin
                k     <= k + IDX_ONE;
                state <= ST_F_PIV;
              end
            end else begin
              i     <= i + IDX_ONE;
              state <= ST_F_FRD;
            end
          end else begin
            j     <= j + IDX_ONE;
            state <= ST_F_J1;
          end
        end
        ST_F_LAST: state <= ST_F_LASTC;
        ST_F_LASTC: begin
          if (w_q == Q_ZERO) begin
            sing  <= 1'b1;
            state <= ST_ZERO;
          end else begin
            c     <= '0;
            r     <= n_m1[IDX_W-1:0];
            state <= ST_U_INIT;
          end
        end
        ST_U_INIT: begin
          acc <= (r == c) ? Q_ONE : Q_ZERO;
          j   <= r + IDX_ONE;
          state <= (SIZE_W'(r) == n_m1) ? ST_U_DRD : ST_U_A;
        end
        ST_U_A: state <= ST_U_B;
        ST_U_B: begin
          mul_x <= w_q;
          mul_y <= u_q;
          state <= ST_U_C;
        end
        ST_U_C: state <= ST_U_D;
        ST_U_D: begin
          acc <= sat_add(acc, qm, 1'b1);
          if (SIZE_W'(j) == n_m1) begin
            state <= ST_U_DRD;
          end else begin
            j     <= j + IDX_ONE;
            state <= ST_U_A;
          end
        end
        ST_U_DRD: state <= ST_U_DIV;
        ST_U_DIV: begin
          div_num <= acc;
          div_den <= w_q;
          div_go  <= 1'b1;
          ret     <= ST_U_WR;
          state   <= ST_DIV_WAIT;
        end
        ST_U_WR: begin
          if (r == '0) begin
            state <= ST_L_INIT;
          end else begin
            r     <= r - IDX_ONE;
            state <= ST_U_INIT;
          end
        end
        ST_L_INIT: begin
          acc   <= (r == c) ? Q_ONE : Q_ZERO;
          j     <= '0;
          state <= (r == '0) ? ST_L_WR : ST_L_A;
        end
        ST_L_A: state <= ST_L_B;
        ST_L_B: begin
          mul_x <= w_q;
          mul_y <= l_q;
          state <= ST_L_C;
        end
        ST_L_C: state <= ST_L_D;
        ST_L_D: begin
          acc <= sat_add(acc, qm, 1'b1);
          if (j + IDX_ONE == r) begin
            state <= ST_L_WR;
          end else begin
            j     <= j + IDX_ONE;
            state <= ST_L_A;
          end
        end
        ST_L_WR: begin
          if (SIZE_W'(r) == n_m1) begin
            if (SIZE_W'(c) == n_m1) begin
              r     <= '0;
              c     <= '0;
              state <= ST_M_INIT;
            end else begin
              c     <= c + IDX_ONE;
              r     <= n_m1[IDX_W-1:0];
              state <= ST_U_INIT;
            end
          end else begin
            r     <= r + IDX_ONE;
            state <= ST_L_INIT;
          end
        end
        ST_M_INIT: begin
          acc   <= Q_ZERO;
          j     <= '0;
          state <= ST_M_A;
        end
        ST_M_A: state <= ST_M_B;
        ST_M_B: begin
          mul_x <= u_q;
          mul_y <= l_q;
          state <= ST_M_C;
        end
        ST_M_C: state <= ST_M_D;
        ST_M_D: begin
          acc <= sat_add(acc, qm, 1'b0);
          if (SIZE_W'(j) == n_m1) begin
            state <= ST_M_OUT;
          end else begin
            j     <= j + IDX_ONE;
            state <= ST_M_A;
          end
        end
        ST_M_OUT: begin
          res   <= acc;
          state <= ST_EMIT;
          if (SIZE_W'(c) == n_m1) begin
            c <= '0;
            if (SIZE_W'(r) == n_m1) begin
              ret <= ST_LOAD;
            end else begin
              r   <= r + IDX_ONE;
              ret <= ST_M_INIT;
            end
          end else begin
            c   <= c + IDX_ONE;
            ret <= ST_M_INIT;
          end
        end
        ST_ZERO: begin
          res   <= Q_ZERO;
          ret   <= emit_last ? ST_LOAD : ST_ZERO;
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!o_valid || result.ready) begin
            o_valid   <= 1'b1;
            o_elem    <= res;
            o_last    <= emit_last;
            o_sing    <= sing;
            out_count <= emit_last ? '0 : out_count + AW'(1);
            state     <= ret;
          end
        end
        ST_DIV_WAIT: begin
          if (div_done) state <= ret;
        end
        default: state <= ST_LOAD;
      endcase
    end
  end

  assign result.valid           = o_valid;
  assign result.inverse_element = o_elem;
  assign result.last_element    = o_last;
  assign result.singular        = o_sing;

`ifndef SYNTHESIS
  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
      o_valid && o_sing |-> o_elem == Q_ZERO)
    else $error("singular result carries a nonzero element");
`endif

endmodule

`default_nettype wire

@@ design/matrix_inverse_lu.sv @@
`default_nettype none

// Streaming inverse of an n by n signed Q16.16 matrix, n set by cfg_data
// (1 to MAX_DIM). Elements enter row-major, one per cycle while the queue
// is not full, into a four-entry queue; the compute side drains it into the
// work store and, after the last element, produces the n*n inverse elements
// row-major with last_element on the final one. n of 1 or 2 uses the
// reciprocal or adjugate rule; larger n uses Doolittle LU without pivoting.
// A zero pivot or determinant gives singular set and all-zero elements.
// Time per matrix is set by one shared multiplier and one bit-serial
// divider. The user must make size writes only while the block is idle;
// the block itself does not enforce this. A size write drops a partly
// loaded matrix.
module matrix_inverse_lu import mil_pkg::*; #(
  parameter int MAX_DIM = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic [SIZE_W-1:0] cfg_data,
  mil_in_if.sink            operand,
  mil_out_if.source         result
);

  logic [SIZE_W-1:0] matrix_size;
  logic [SIZE_W-1:0] dim;
  logic              q_full;
  logic              q_push;
  load_item_t        q_in;
  logic              q_avail;
  logic              q_pop;
  load_item_t        q_out;

  // Size register.
  always_ff @(posedge clk) begin
    if (rst) matrix_size <= SIZE_W'(3);
    else if (cfg_write) matrix_size <= cfg_data;
  end

  assign dim = eff_size(matrix_size, SIZE_W'(MAX_DIM));

  mil_front u_front (
    .clk      (clk),
    .rst      (rst),
    .dim      (dim),
    .cfg_write(cfg_write),
    .operand  (operand),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  mil_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_item(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .avail    (q_avail),
    .pop_item (q_out)
  );

  mil_back #(
    .MAX_DIM(MAX_DIM)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .dim    (dim),
    .q_valid(q_avail),
    .q_item (q_out),
    .q_pop  (q_pop),
    .result (result)
  );

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
  import mil_pkg::*;

  localparam int DIM = 8;
  localparam int STALL_LIMIT = 40000;
  localparam int SETTLE_CYCLES = 200;
  localparam int RANDOM_ITEMS = 310;

  // Kinds of generated matrix content.
  typedef enum int {MK_DOMINANT, MK_NOISE, MK_DUP_ROWS, MK_ZERO_LEAD} mat_kind_e;

  typedef struct {
    q_t   value;
    logic last;
    logic sing;
  } inv_item_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [SIZE_W-1:0] cfg_data;

  mil_in_if  in_ch();
  mil_out_if out_ch();

  matrix_inverse_lu #(.MAX_DIM(DIM)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_data(cfg_data),
    .operand(in_ch.sink),
    .result(out_ch.source)
  );

  // Clock with a 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block state used to predict inverses.
  logic [SIZE_W-1:0] size_reg;
  int unsigned loaded;
  q_t lu_store [DIM*DIM];
  q_t up_inv [DIM*DIM];
  q_t low_inv [DIM*DIM];

  q_t elem_pending [$];
  inv_item_t inv_expected [$];

  int errors = 0;
  int elems_sent = 0;
  int results_seen = 0;
  int matrices_done = 0;
  int singular_seen = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  logic in_took = 1'b0;
  int stall_count = 0;

  function automatic q_t sat64(input logic signed [63:0] v);
    if (v > 64'sd2147483647) return Q_MAX;
    if (v < -64'sd2147483648) return Q_MIN;
    return v[31:0];
  endfunction

  function automatic q_t fx_mul(input q_t a, input q_t b);
    logic signed [63:0] x, y, p;
    x = a;
    y = b;
    p = x * y + 64'sd32768;
    return sat64(p >>> 16);
  endfunction

  function automatic q_t fx_div(input q_t a, input q_t b);
    logic signed [63:0] x, y;
    x = a;
    y = b;
    return sat64((x * 64'sd65536) / y);
  endfunction

  function automatic q_t fx_add(input q_t a, input q_t b);
    logic signed [63:0] x, y;
    x = a;
    y = b;
    return sat64(x + y);
  endfunction

  function automatic q_t fx_sub(input q_t a, input q_t b);
    logic signed [63:0] x, y;
    x = a;
    y = b;
    return sat64(x - y);
  endfunction

  function automatic int dim_of(input logic [SIZE_W-1:0] s);
    if (s == 0) return 1;
    if (s > DIM) return DIM;
    return s;
  endfunction

  // Factor, solve and multiply once a whole matrix has arrived.
  task automatic compute_inverse(input int n);
    q_t res [DIM*DIM];
    logic ok;
    q_t a, b, c, d, det, piv, f, acc;
    inv_item_t it;
    ok = 1'b1;
    for (int k = 0; k < DIM*DIM; k++) res[k] = Q_ZERO;
    if (n == 1) begin
      a = lu_store[0];
      if (a == 0) ok = 1'b0;
      else res[0] = fx_div(Q_ONE, a);
    end else if (n == 2) begin
      a = lu_store[0];
      b = lu_store[1];
      c = lu_store[DIM];
      d = lu_store[DIM+1];
      det = fx_sub(fx_mul(a, d), fx_mul(b, c));
      if (det == 0) ok = 1'b0;
      else begin
        res[0] = fx_div(d, det);
        res[1] = fx_div(fx_sub(Q_ZERO, b), det);
        res[2] = fx_div(fx_sub(Q_ZERO, c), det);
        res[3] = fx_div(a, det);
      end
    end else begin
      // Doolittle factorization in place, no pivoting.
      for (int k = 0; k + 1 < n && ok; k++) begin
        piv = lu_store[k*DIM+k];
        if (piv == 0) ok = 1'b0;
        else begin
          for (int i = k + 1; i < n; i++) begin
            f = fx_div(lu_store[i*DIM+k], piv);
            lu_store[i*DIM+k] = f;
            for (int j = k + 1; j < n; j++)
              lu_store[i*DIM+j] = fx_sub(lu_store[i*DIM+j], fx_mul(f, lu_store[k*DIM+j]));
          end
        end
      end
      if (ok && lu_store[(n-1)*DIM+n-1] == 0) ok = 1'b0;
      if (ok) begin
        // Triangular inverses column by column.
        for (int col = 0; col < n; col++) begin
          for (int r = n - 1; r >= 0; r--) begin
            acc = (r == col) ? Q_ONE : Q_ZERO;
            for (int j = r + 1; j < n; j++)
              acc = fx_sub(acc, fx_mul(lu_store[r*DIM+j], up_inv[j*DIM+col]));
            up_inv[r*DIM+col] = fx_div(acc, lu_store[r*DIM+r]);
          end
          for (int r = 0; r < n; r++) begin
            acc = (r == col) ? Q_ONE : Q_ZERO;
            for (int j = 0; j < r; j++)
              acc = fx_sub(acc, fx_mul(lu_store[r*DIM+j], low_inv[j*DIM+col]));
            low_inv[r*DIM+col] = acc;
          end
        end
        for (int r = 0; r < n; r++)
          for (int col = 0; col < n; col++) begin
            acc = Q_ZERO;
            for (int j = 0; j < n; j++)
              acc = fx_add(acc, fx_mul(up_inv[r*DIM+j], low_inv[j*DIM+col]));
            res[r*n+col] = acc;
          end
      end
    end
    for (int k = 0; k < n*n; k++) begin
      it.value = ok ? res[k] : Q_ZERO;
      it.last = (k + 1 == n*n);
      it.sing = !ok;
      inv_expected.push_back(it);
    end
  endtask

  // Store one accepted element and predict the inverse when it completes a matrix.
  task automatic take_element(input q_t el);
    int n, total;
    n = dim_of(size_reg);
    total = n * n;
    if (loaded >= total) loaded = 0;
    lu_store[(loaded / n) * DIM + (loaded % n)] = el;
    loaded++;
    if (loaded == total) begin
      loaded = 0;
      compute_inverse(n);
    end
  endtask

  // Input driver and output ready, changed on the falling edge.
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      out_ch.ready <= 1'b0;
    end else begin
      if (!in_ch.valid || in_took) begin
        if (elem_pending.size() > 0 && $urandom_range(99) >= snd_idle) begin
          in_ch.valid <= 1'b1;
          in_ch.element <= elem_pending.pop_front();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
      out_ch.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  // Monitor: feed the predictor with accepted elements and check results.
  always @(posedge clk) begin
    inv_item_t want;
    in_took <= !rst && in_ch.valid && in_ch.ready;
    if (!rst) begin
      if (in_ch.valid && in_ch.ready) take_element(in_ch.element);
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (inv_expected.size() == 0) begin
          errors++;
          $display("%0t: unexpected item, actual %h last %b singular %b", $time,
                   out_ch.inverse_element, out_ch.last_element, out_ch.singular);
        end else begin
          want = inv_expected.pop_front();
          if (out_ch.inverse_element !== want.value || out_ch.last_element !== want.last ||
              out_ch.singular !== want.sing) begin
            errors++;
            $display("%0t: mismatch, expected %h last %b singular %b, actual %h last %b singular %b",
                     $time, want.value, want.last, want.sing, out_ch.inverse_element,
                     out_ch.last_element, out_ch.singular);
          end
          if (want.last) begin
            matrices_done++;
            if (want.sing) singular_seen++;
          end
        end
      end
    end
  end

  // Watchdog on cycles with no item moving on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || rst) begin
      stall_count <= 0;
    end else begin
      stall_count <= stall_count + 1;
      if (stall_count >= STALL_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // Wait until all elements are in and all inverses are out, then let the block settle.
  task automatic drain();
    while (elem_pending.size() > 0 || in_ch.valid === 1'b1 || inv_expected.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input logic [SIZE_W-1:0] s);
    drain();
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data <= s;
    @(negedge clk);
    cfg_write <= 1'b0;
    size_reg = s;
    loaded = 0;
  endtask

  task automatic push_elem(input q_t v);
    elem_pending.push_back(v);
    elems_sent++;
  endtask

  // Queue one matrix of the given kind, or only its first count elements.
  task automatic send_matrix(input mat_kind_e kind, input int count);
    int n;
    q_t m [DIM*DIM];
    n = dim_of(size_reg);
    for (int r = 0; r < n; r++)
      for (int c = 0; c < n; c++) begin
        if (kind == MK_NOISE) m[r*n+c] = $urandom;
        else if (r == c)
          m[r*n+c] = ($urandom_range(1) ? 1 : -1) *
                     (($urandom_range(n + 4, n + 1) << 16) + $urandom_range(65535));
        else m[r*n+c] = $signed($urandom_range(131072)) - 65536;
      end
    if (kind == MK_DUP_ROWS && n >= 2)
      for (int c = 0; c < n; c++) m[n+c] = m[c];
    if (kind == MK_ZERO_LEAD) m[0] = Q_ZERO;
    for (int k = 0; k < n*n && k < count; k++) push_elem(m[k]);
  endtask

  initial begin
    int pick, count;
    mat_kind_e kind;
    in_ch.valid = 1'b0;
    in_ch.element = Q_ZERO;
    out_ch.ready = 1'b0;
    cfg_write = 1'b0;
    cfg_data = '0;
    size_reg = 3;
    loaded = 0;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: zero pivot at the reset size.
    send_matrix(MK_ZERO_LEAD, 99);
    // Reciprocal of the extremes, of zero and of the smallest step.
    set_size(1);
    push_elem(Q_MAX);
    push_elem(Q_MIN);
    push_elem(Q_ZERO);
    push_elem(32'sd1);
    // Zero determinant, then a saturating adjugate.
    set_size(2);
    push_elem(Q_ONE); push_elem(Q_ONE); push_elem(Q_ONE); push_elem(Q_ONE);
    push_elem(Q_MAX); push_elem(Q_MIN); push_elem(Q_ZERO); push_elem(-32'sd65536);
    // A size write in the middle of a load drops the partial matrix.
    push_elem(32'sh0002_0000); push_elem(Q_ONE); push_elem(-32'sd1);
    set_size(0);
    push_elem(-32'sd2);

    // Random part in three idling phases.
    elems_sent = 0;
    while (elems_sent < RANDOM_ITEMS) begin
      if (elems_sent < RANDOM_ITEMS / 3) begin
        snd_idle = 35; rcv_idle = 54;
      end else if (elems_sent < 2 * RANDOM_ITEMS / 3) begin
        snd_idle = 54; rcv_idle = 35;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      pick = $urandom_range(99);
      if (pick < 8) set_size($urandom_range(15, 5));
      else if (pick < 12) set_size(0);
      else set_size($urandom_range(4, 1));
      count = $urandom_range(3, 1);
      for (int i = 0; i < count; i++) begin
        pick = $urandom_range(99);
        if (pick < 70) kind = MK_DOMINANT;
        else if (pick < 85) kind = MK_NOISE;
        else if (pick < 93) kind = MK_DUP_ROWS;
        else kind = MK_ZERO_LEAD;
        // Now and then hold the sender until every inverse is out.
        if ($urandom_range(9) == 0) drain();
        send_matrix(kind, 99);
      end
      // Occasionally send only the first two elements of a matrix before the next size write.
      if ($urandom_range(9) == 0) send_matrix(MK_NOISE, 2);
    end

    drain();
    $display("Checked %0d inverse items over %0d matrices, %0d of them singular.",
             results_seen, matrices_done, singular_seen);
    $display("Sizes 0 to 15 used under three idle patterns, with partial loads dropped.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/mil_pkg.sv
design/mil_if.sv
design/mil_front.sv
design/mil_queue.sv
design/mil_div.sv
design/mil_back.sv
design/matrix_inverse_lu.sv
tb/testbench.sv
